// File: rtl/jsu_pkg.sv
// Package with the types, codes and helper functions of the JSON string unescaper.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

   typedef enum logic [2:0] {
      ST_DATA       = 3'd0,
      ST_DONE       = 3'd1,
      ST_UNEXP_END  = 3'd2,
      ST_CTRL       = 3'd3,
      ST_BAD_HEX    = 3'd4,
      ST_BAD_ESC    = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_ESCAPE = 2'd1,
      MODE_HEX    = 2'd2
   } mode_type;

   localparam int MaxResults = 5;
   localparam int CountWidth = $clog2(MaxResults + 1);
   localparam int IndexWidth = $clog2(MaxResults);

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_LOW_B     = 8'h62;
   localparam logic [7:0] CH_LOW_F     = 8'h66;
   localparam logic [7:0] CH_LOW_N     = 8'h6E;
   localparam logic [7:0] CH_LOW_R     = 8'h72;
   localparam logic [7:0] CH_LOW_T     = 8'h74;
   localparam logic [7:0] CH_LOW_U     = 8'h75;
   localparam logic [7:0] CTRL_MAX     = 8'h1F;

   localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
   localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
   localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE    = 21'h10000;

   typedef struct packed {
      mode_type    mode;
      logic [1:0]  hex_cnt;
      logic [15:0] hex_acc;
      logic [15:0] held_cp;
      logic        held_valid;
   } dec_state_type;

   localparam dec_state_type DEC_STATE_RESET = '{
      mode: MODE_NORMAL, hex_cnt: 2'd0, hex_acc: 16'd0, held_cp: 16'd0, held_valid: 1'b0
   };

   typedef struct packed {
      status_type status;
      logic [7:0] data;
   } rsp_item_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      len;
   } utf8_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic       known;
      logic [7:0] value;
   } esc_type;

   function automatic utf8_type utf8_encode(input logic [20:0] cp);
      utf8_type r;
      r = '0;
      if (cp < 21'h80) begin
         r.len      = 3'd1;
         r.bytes[0] = cp[7:0];
      end else if (cp < 21'h800) begin
         r.len      = 3'd2;
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
         r.len      = 3'd3;
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         r.len      = 3'd4;
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
      end
      return r;
   endfunction

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type r;
      r = '0;
      case (c) inside
         [8'h30:8'h39]: begin
            r.valid = 1'b1;
            r.value = 4'(c - 8'h30);
         end
         [8'h61:8'h66]: begin
            r.valid = 1'b1;
            r.value = 4'(c - 8'h57);
         end
         [8'h41:8'h46]: begin
            r.valid = 1'b1;
            r.value = 4'(c - 8'h37);
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic esc_type escape_map(input logic [7:0] c);
      esc_type r;
      r.known = 1'b1;
      r.value = c;
      unique case (c)
         CH_LOW_B: r.value = 8'h08;
         CH_LOW_F: r.value = 8'h0C;
         CH_LOW_N: r.value = 8'h0A;
         CH_LOW_R: r.value = 8'h0D;
         CH_LOW_T: r.value = 8'h09;
         CH_QUOTE, CH_BACKSLASH, CH_SLASH: r.value = c;
         default: r.known = 1'b0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/jsu_decode.sv
// Combinational decode of one string byte into its result list and the next parser state.
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode
   import jsu_pkg::*;
(
   input  dec_state_type                   state,
   input  logic [7:0]                      in_byte,
   input  logic                            end_of_input,
   output rsp_item_type [MaxResults-1:0]   results,
   output logic [CountWidth-1:0]           count,
   output dec_state_type                   state_next
);

   utf8_type      enc;
   hex_type       hex;
   esc_type       esc;
   logic [15:0]   acc_next;
   logic          pair;
   logic          enc_en;
   logic [20:0]   enc_cp;
   logic          tail_en;
   rsp_item_type  tail;
   logic          finished;
   dec_state_type ns;

   assign hex      = hex_decode(in_byte);
   assign esc      = escape_map(in_byte);
   assign acc_next = {state.hex_acc[11:0], hex.value};
   assign pair     = state.held_valid
                     && state.held_cp >= HIGH_SURR_LO && state.held_cp <= HIGH_SURR_HI
                     && acc_next >= LOW_SURR_LO && acc_next <= LOW_SURR_HI;
   assign enc      = utf8_encode(enc_cp);

   always_comb begin
      ns       = state;
      enc_en   = 1'b0;
      enc_cp   = {5'd0, state.held_cp};
      tail_en  = 1'b0;
      tail     = '{status: ST_DATA, data: 8'd0};
      finished = 1'b0;
      unique case (state.mode)
         MODE_NORMAL: begin
            if (in_byte == CH_QUOTE) begin
               enc_en   = state.held_valid;
               tail_en  = 1'b1;
               tail     = '{status: ST_DONE, data: 8'd0};
               finished = 1'b1;
            end else if (in_byte <= CTRL_MAX) begin
               tail_en  = 1'b1;
               tail     = '{status: ST_CTRL, data: 8'd0};
               finished = 1'b1;
            end else if (in_byte == CH_BACKSLASH) begin
               ns.mode = MODE_ESCAPE;
            end else begin
               enc_en        = state.held_valid;
               ns.held_valid = 1'b0;
               ns.held_cp    = 16'd0;
               tail_en       = 1'b1;
               tail          = '{status: ST_DATA, data: in_byte};
            end
         end
         MODE_ESCAPE: begin
            if (in_byte == CH_LOW_U) begin
               ns.mode    = MODE_HEX;
               ns.hex_cnt = 2'd0;
               ns.hex_acc = 16'd0;
            end else if (esc.known) begin
               enc_en        = state.held_valid;
               ns.held_valid = 1'b0;
               ns.held_cp    = 16'd0;
               ns.mode       = MODE_NORMAL;
               tail_en       = 1'b1;
               tail          = '{status: ST_DATA, data: esc.value};
            end else begin
               tail_en  = 1'b1;
               tail     = '{status: ST_BAD_ESC, data: 8'd0};
               finished = 1'b1;
            end
         end
         MODE_HEX: begin
            if (!hex.valid) begin
               tail_en  = 1'b1;
               tail     = '{status: ST_BAD_HEX, data: 8'd0};
               finished = 1'b1;
            end else if (state.hex_cnt == 2'd3) begin
               if (pair) begin
                  enc_en        = 1'b1;
                  enc_cp        = 21'({1'b0, state.held_cp[9:0], acc_next[9:0]}) + SUPP_BASE;
                  ns.held_valid = 1'b0;
                  ns.held_cp    = 16'd0;
               end else begin
                  enc_en        = state.held_valid;
                  ns.held_valid = 1'b1;
                  ns.held_cp    = acc_next;
               end
               ns.mode    = MODE_NORMAL;
               ns.hex_cnt = 2'd0;
               ns.hex_acc = 16'd0;
            end else begin
               ns.hex_cnt = 2'(state.hex_cnt + 2'd1);
               ns.hex_acc = acc_next;
            end
         end
         default: begin
            ns = DEC_STATE_RESET;
         end
      endcase
   end

   always_comb begin
      logic [CountWidth-1:0] n;
      n       = '0;
      results = '0;
      if (enc_en) begin
         for (int i = 0; i < 4; i++) begin
            if (3'(i) < enc.len) begin
               results[n[IndexWidth-1:0]] = '{status: ST_DATA, data: enc.bytes[i[1:0]]};
               n = CountWidth'(n + 1'b1);
            end
         end
      end
      if (tail_en) begin
         results[n[IndexWidth-1:0]] = tail;
         n = CountWidth'(n + 1'b1);
      end
      if (!finished && end_of_input) begin
         results[n[IndexWidth-1:0]] = (ns.mode == MODE_HEX)
                                      ? '{status: ST_BAD_HEX, data: 8'd0}
                                      : '{status: ST_UNEXP_END, data: 8'd0};
         n = CountWidth'(n + 1'b1);
      end
      count = n;
   end

   assign state_next = (finished || end_of_input) ? DEC_STATE_RESET : ns;

endmodule

`default_nettype wire

// File: rtl/json_string_unescape_utf8_unit.sv
// Top level of the JSON string unescaper that turns string body bytes into UTF-8.
//
// The req channel carries one byte of a JSON string body per transaction, starting
// after the opening quote; req_tlast marks the last byte of the buffer. The rsp
// channel carries the results: rsp_tuser is the status (data byte, string done or
// one of four errors), rsp_tdata the UTF-8 byte for data results and zero otherwise,
// and rsp_tlast marks the final result caused by one request byte. A byte may cause
// no result at all, for instance a backslash or an incomplete \u escape.
// An accepted byte lands in the input register; the result register shows its results.
// A byte with n results holds the input register until the last has moved on, as the
// result register moves one result per cycle while the receiver takes them, so the block
// takes one byte per cycle while each byte gives at most one result and the receiver does
// not stall; a byte without results needs no free result register. A \u escape is held
// so that a surrogate pair becomes one 4-byte character, which makes bursts of up to five
// results. Reset clears the parser state and empties both registers. When the receiver
// stalls, the result register holds its transaction and req_tready falls once the waiting
// byte has no more room to move its results.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8_unit
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [2:0] rsp_tuser,   // [2:0] status
   output logic       rsp_tlast
);

   logic                          in_valid_ff, in_valid_in;
   logic [7:0]                    in_byte_ff, in_byte_in;
   logic                          in_end_ff, in_end_in;
   dec_state_type                 state_ff, state_in;
   logic [IndexWidth-1:0]         idx_ff, idx_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_item_type                  rsp_item_ff, rsp_item_in;
   logic                          rsp_last_ff, rsp_last_in;

   rsp_item_type [MaxResults-1:0] results;
   logic [CountWidth-1:0]         count;
   dec_state_type                 state_next;
   logic                          out_free;
   logic                          take;
   logic                          is_final;
   logic                          retire;
   logic                          req_accept;

   jsu_decode u_decode (
      .state        (state_ff),
      .in_byte      (in_byte_ff),
      .end_of_input (in_end_ff),
      .results      (results),
      .count        (count),
      .state_next   (state_next)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign is_final   = (CountWidth'(idx_ff) == CountWidth'(count - 1'b1));
   assign take       = in_valid_ff && (count != '0) && out_free;
   assign retire     = in_valid_ff && ((count == '0) || (out_free && is_final));
   assign req_tready = !in_valid_ff || retire;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      in_end_in    = in_end_ff;
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_last_in  = rsp_last_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = results[idx_ff];
         rsp_last_in  = is_final;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (retire) begin
         state_in    = state_next;
         idx_in      = '0;
         in_valid_in = 1'b0;
      end else if (take) begin
         idx_in = IndexWidth'(idx_ff + 1'b1);
      end
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_end_in   = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= DEC_STATE_RESET;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_byte_ff  <= in_byte_in;
      in_end_ff   <= in_end_in;
      rsp_item_ff <= rsp_item_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_item_ff.data;
   assign rsp_tuser  = rsp_item_ff.status;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// File: rtl/jsu_checker.sv
// Port-level checker for the JSON string unescaper and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module jsu_checker
   import jsu_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [2:0] rsp_tuser,
   input logic       rsp_tlast
);

   // A stalled result transaction keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   // A waiting request transaction keeps its contents.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=>
         req_tvalid && $stable(req_tdata) && $stable(req_tlast))
      else $error("req transaction changed while waiting");

   // Any status other than a data byte ends the results of its request byte.
   a_status_final: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_DATA |-> rsp_tlast && rsp_tdata == 8'd0)
      else $error("non-data status not final or carries data");

   // Reset empties both registers.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not empty after reset");

   // A byte holding the input register always has a result waiting in the next cycle.
   a_stall_has_result: assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> rsp_tvalid)
      else $error("input stalled without a pending result");

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// File: sim/utf8_unescape_checker.sv
// Checker that predicts the UTF-8 output of the string unescaper and compares every result.
`timescale 1ns / 1ps

module utf8_unescape_checker
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic [2:0] rsp_tuser,
   input  logic       rsp_tlast,
   output int         fail_count,
   output int         pending_count,
   output int         beats_checked,
   output int         strings_done,
   output int         errors_seen
);

   typedef struct packed {
      status_type status;
      logic [7:0] data;
      logic       last;
   } unescaped_beat_type;

   unescaped_beat_type predicted_beats[$];
   unescaped_beat_type step_beats[$];

   mode_type    dec_mode;
   logic [1:0]  dec_hex_cnt;
   logic [15:0] dec_hex_acc;
   logic [15:0] dec_held_cp;
   logic        dec_held_valid;

   int failures   = 0;
   int mismatches = 0;
   int checked    = 0;
   int done_seen  = 0;
   int err_seen   = 0;

   task automatic clear_decoder();
      dec_mode       = MODE_NORMAL;
      dec_hex_cnt    = 2'd0;
      dec_hex_acc    = 16'd0;
      dec_held_cp    = 16'd0;
      dec_held_valid = 1'b0;
   endtask

   task automatic emit(input status_type st, input logic [7:0] b);
      unescaped_beat_type beat;
      beat.status = st;
      beat.data   = b;
      beat.last   = 1'b0;
      step_beats  = {step_beats, beat};
   endtask

   task automatic emit_codepoint(input logic [20:0] cp);
      if (cp < 21'h80) begin
         emit(ST_DATA, cp[7:0]);
      end else if (cp < 21'h800) begin
         emit(ST_DATA, 8'(cp >> 6) | 8'hC0);
         emit(ST_DATA, 8'(cp & 21'h3F) | 8'h80);
      end else if (cp < 21'h10000) begin
         emit(ST_DATA, 8'(cp >> 12) | 8'hE0);
         emit(ST_DATA, 8'((cp >> 6) & 21'h3F) | 8'h80);
         emit(ST_DATA, 8'(cp & 21'h3F) | 8'h80);
      end else begin
         emit(ST_DATA, 8'((cp >> 18) & 21'h07) | 8'hF0);
         emit(ST_DATA, 8'((cp >> 12) & 21'h3F) | 8'h80);
         emit(ST_DATA, 8'((cp >> 6) & 21'h3F) | 8'h80);
         emit(ST_DATA, 8'(cp & 21'h3F) | 8'h80);
      end
   endtask

   task automatic flush_held();
      if (dec_held_valid) emit_codepoint(21'(dec_held_cp));
      dec_held_valid = 1'b0;
      dec_held_cp    = 16'd0;
   endtask

   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   // Returns the translated byte in the low bits and a known flag on top.
   function automatic logic [8:0] simple_escape(input logic [7:0] c);
      case (c)
         CH_LOW_B:                         return {1'b1, 8'h08};
         CH_LOW_F:                         return {1'b1, 8'h0C};
         CH_LOW_N:                         return {1'b1, 8'h0A};
         CH_LOW_R:                         return {1'b1, 8'h0D};
         CH_LOW_T:                         return {1'b1, 8'h09};
         CH_QUOTE, CH_BACKSLASH, CH_SLASH: return {1'b1, c};
         default:                          return {1'b0, 8'h00};
      endcase
   endfunction

   task automatic decode_byte(input logic [7:0] c, input logic at_end);
      logic            finished;
      logic [8:0]      mapped;
      int              nib;
      logic [15:0]     cp;
      logic [20:0]     pair;
      finished = 1'b0;
      step_beats.delete();
      case (dec_mode)
         MODE_NORMAL: begin
            if (c == CH_QUOTE) begin
               flush_held();
               emit(ST_DONE, 8'h00);
               finished = 1'b1;
            end else if (c <= CTRL_MAX) begin
               emit(ST_CTRL, 8'h00);
               finished = 1'b1;
            end else if (c == CH_BACKSLASH) begin
               dec_mode = MODE_ESCAPE;
            end else begin
               flush_held();
               emit(ST_DATA, c);
            end
         end
         MODE_ESCAPE: begin
            mapped = simple_escape(c);
            if (c == CH_LOW_U) begin
               dec_mode    = MODE_HEX;
               dec_hex_cnt = 2'd0;
               dec_hex_acc = 16'd0;
            end else if (mapped[8]) begin
               flush_held();
               emit(ST_DATA, mapped[7:0]);
               dec_mode = MODE_NORMAL;
            end else begin
               emit(ST_BAD_ESC, 8'h00);
               finished = 1'b1;
            end
         end
         default: begin
            nib = hex_nibble(c);
            if (nib < 0) begin
               emit(ST_BAD_HEX, 8'h00);
               finished = 1'b1;
            end else begin
               dec_hex_acc = {dec_hex_acc[11:0], 4'(nib)};
               if (dec_hex_cnt == 2'd3) begin
                  cp = dec_hex_acc;
                  if (dec_held_valid && dec_held_cp >= HIGH_SURR_LO
                      && dec_held_cp <= HIGH_SURR_HI
                      && cp >= LOW_SURR_LO && cp <= LOW_SURR_HI) begin
                     pair = ((21'(dec_held_cp - HIGH_SURR_LO) << 10)
                             | 21'(cp - LOW_SURR_LO)) + SUPP_BASE;
                     emit_codepoint(pair);
                     dec_held_valid = 1'b0;
                     dec_held_cp    = 16'd0;
                  end else begin
                     flush_held();
                     dec_held_cp    = cp;
                     dec_held_valid = 1'b1;
                  end
                  dec_mode    = MODE_NORMAL;
                  dec_hex_cnt = 2'd0;
                  dec_hex_acc = 16'd0;
               end else begin
                  dec_hex_cnt = dec_hex_cnt + 2'd1;
               end
            end
         end
      endcase
      if (!finished && at_end) begin
         if (dec_mode == MODE_HEX) emit(ST_BAD_HEX, 8'h00);
         else emit(ST_UNEXP_END, 8'h00);
         finished = 1'b1;
      end
      if (finished) clear_decoder();
      if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
      predicted_beats = {predicted_beats, step_beats};
   endtask

   task automatic check_beat();
      unescaped_beat_type want;
      checked++;
      if (rsp_tuser == ST_DONE) done_seen++;
      else if (rsp_tuser != ST_DATA) err_seen++;
      if (predicted_beats.size() == 0) begin
         failures++;
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: unexpected transaction status=%0d data=%02h last=%0b",
                     rsp_tuser, rsp_tdata, rsp_tlast);
      end else begin
         want = predicted_beats.pop_front();
         if (rsp_tuser !== want.status || rsp_tdata !== want.data
             || rsp_tlast !== want.last) begin
            failures++;
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: expected status=%0d data=%02h last=%0b, %s%0d data=%02h last=%0b",
                        want.status, want.data, want.last, "got status=",
                        rsp_tuser, rsp_tdata, rsp_tlast);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
         predicted_beats.delete();
      end else begin
         if (req_tvalid && req_tready) decode_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_beat();
      end
      fail_count    <= failures;
      pending_count <= predicted_beats.size();
      beats_checked <= checked;
      strings_done  <= done_seen;
      errors_seen   <= err_seen;
   end

endmodule

// File: sim/tb_json_string_unescape_utf8_unit.sv
// Testbench top that streams JSON string bytes into the unescaper and reports the verdict.
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8_unit;
   import jsu_pkg::*;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic       rsp_tlast;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int bytes_sent  = 0;
   int fail_count;
   int pending_count;
   int beats_checked;
   int strings_done;
   int errors_seen;

   json_string_unescape_utf8_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   utf8_unescape_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .beats_checked (beats_checked),
      .strings_done  (strings_done),
      .errors_seen   (errors_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   initial begin
      #2000000;
      $display("json_string_unescape_utf8_unit: mismatch");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic eoi);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(0, 99) < tx_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eoi;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(input string s, input logic eoi_on_last);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], eoi_on_last && i == s.len() - 1);
   endtask

   // Holds the sender off until every predicted result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return "0" + 8'(n);
      return (($urandom_range(0, 1) != 0) ? "a" : "A") + 8'(n) - 8'd10;
   endfunction

   task automatic send_unicode(input logic [15:0] cp, input int digits, input logic eoi);
      send_byte(CH_BACKSLASH, 1'b0);
      send_byte(CH_LOW_U, eoi && digits == 0);
      for (int i = 0; i < digits; i++)
         send_byte(hex_char(cp[15 - 4 * i -: 4]), eoi && i == digits - 1);
   endtask

   function automatic logic [15:0] random_codepoint();
      case ($urandom_range(0, 4))
         0:       return 16'($urandom_range(0, 16'h7F));
         1:       return 16'($urandom_range(16'h80, 16'h7FF));
         2:       return 16'($urandom_range(16'h800, 16'hFFFF));
         3:       return 16'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI));
         default: return 16'($urandom_range(LOW_SURR_LO, LOW_SURR_HI));
      endcase
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(8'h20, 8'hFF));
      while (b == CH_QUOTE || b == CH_BACKSLASH);
      return b;
   endfunction

   function automatic logic [7:0] escape_letter();
      case ($urandom_range(0, 7))
         0:       return CH_LOW_B;
         1:       return CH_LOW_F;
         2:       return CH_LOW_N;
         3:       return CH_LOW_R;
         4:       return CH_LOW_T;
         5:       return CH_QUOTE;
         6:       return CH_BACKSLASH;
         default: return CH_SLASH;
      endcase
   endfunction

   task automatic send_token();
      int         pick;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
         send_byte(plain_byte(), 1'b0);
      end else if (pick < 52) begin
         send_byte(CH_BACKSLASH, 1'b0);
         send_byte(escape_letter(), 1'b0);
      end else if (pick < 66) begin
         send_unicode(random_codepoint(), 4, 1'b0);
      end else if (pick < 76) begin
         send_unicode(16'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI)), 4, 1'b0);
         send_unicode(16'($urandom_range(LOW_SURR_LO, LOW_SURR_HI)), 4, 1'b0);
      end else if (pick < 84) begin
         send_byte(CH_QUOTE, $urandom_range(0, 9) == 0);
      end else if (pick < 87) begin
         send_byte(8'($urandom_range(0, CTRL_MAX)), 1'b0);
      end else if (pick < 90) begin
         do b = 8'($urandom_range(0, 255));
         while (b inside {CH_LOW_B, CH_LOW_F, CH_LOW_N, CH_LOW_R, CH_LOW_T, CH_LOW_U,
                          CH_QUOTE, CH_BACKSLASH, CH_SLASH});
         send_byte(CH_BACKSLASH, 1'b0);
         send_byte(b, 1'b0);
      end else if (pick < 93) begin
         do b = 8'($urandom_range(0, 255));
         while (b inside {["0":"9"], ["a":"f"], ["A":"F"]});
         send_unicode(random_codepoint(), $urandom_range(0, 3), 1'b0);
         send_byte(b, 1'b0);
      end else begin
         case ($urandom_range(0, 3))
            0: send_byte(plain_byte(), 1'b1);
            1: begin
               send_byte(CH_BACKSLASH, $urandom_range(0, 1) == 0);
               if (req_tlast == 1'b0) send_byte(escape_letter(), 1'b1);
            end
            2: send_unicode(random_codepoint(), $urandom_range(0, 3), 1'b1);
            default: send_unicode(random_codepoint(), 4, 1'b1);
         endcase
      end
   endtask

   task automatic run_phase(input int tx_pct, input int rx_pct, input int count);
      int goal;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      goal        = bytes_sent + count;
      while (bytes_sent < goal) send_token();
      drain_results();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      tx_idle_pct = 7;
      rx_idle_pct = 58;

      send_byte(8'h20, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text("\\t", 1'b0);
      send_text("\\uD83D\\ude00", 1'b0);
      send_byte(CH_QUOTE, 1'b0);
      send_byte(8'h00, 1'b0);
      send_text("\\q", 1'b0);
      send_byte(CH_QUOTE, 1'b1);
      send_byte("x", 1'b1);
      send_text("\\u1", 1'b1);
      drain_results();

      run_phase(7, 58, 62);
      run_phase(58, 7, 62);
      run_phase(0, 0, 62);

      repeat (10) @(posedge clock);
      $display("Sent %0d string bytes through three idle patterns; checked %0d results,",
               bytes_sent, beats_checked);
      $display("among them %0d completed strings and %0d error reports.",
               strings_done, errors_seen);
      if (fail_count == 0 && pending_count == 0) begin
         $display("json_string_unescape_utf8_unit: match");
      end else begin
         $display("json_string_unescape_utf8_unit: mismatch");
      end
      $finish;
   end

endmodule
